### sv/pli_pkg.sv
// shared types, constants and codes of the piecewise linear interpolator
package pli_pkg;

    localparam int MAX_POINTS = 64;
    localparam int DATA_W     = 32;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int ENT_W      = 2 * DATA_W;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int SUM_W      = PROD_W + 3;

    typedef enum logic [1:0] {
        MODE_CLEAR = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_QUERY = 2'd2,
        MODE_NOP   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_FEW   = 3'd2,
        ST_EQKEY = 3'd3,
        ST_SAT   = 3'd4
    } t_status;

    typedef struct packed {
        logic        [1:0]        mode;
        logic signed [DATA_W-1:0] point_x;
        logic signed [DATA_W-1:0] point_y;
        logic signed [DATA_W-1:0] query_value;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic        [2:0]        status;
        logic        [CNT_W-1:0]  point_count;
    } t_out_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] key;
        logic signed [DATA_W-1:0] value;
    } t_entry;

endpackage

### sv/pli_ram.sv
// generic single write port, single read port ram with registered read
module pli_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### sv/pli_div.sv
// unsigned restoring divider, two quotient bits per cycle, with round-half-up flag
module pli_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pli_pkg::PROD_W-1:0]  i_dividend,
    input  logic [pli_pkg::DIFF_W-1:0]  i_divisor,
    output logic                        o_done,
    output logic [pli_pkg::PROD_W-1:0]  o_quot,
    output logic                        o_round_up
);
    import pli_pkg::*;

    localparam int STEPS  = PROD_W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [PROD_W-1:0] r_q, n_q;
    logic [DIFF_W-1:0] r_rem, n_rem;
    logic [DIFF_W-1:0] r_d, n_d;

    logic [DIFF_W:0]   s1, s2;
    logic              ge1, ge2;
    logic [DIFF_W-1:0] rem1, rem2;

    always_comb begin
        s1   = {r_rem, r_q[PROD_W-1]};
        ge1  = s1 >= {1'b0, r_d};
        rem1 = ge1 ? DIFF_W'(s1 - {1'b0, r_d}) : DIFF_W'(s1);
        s2   = {rem1, r_q[PROD_W-2]};
        ge2  = s2 >= {1'b0, r_d};
        rem2 = ge2 ? DIFF_W'(s2 - {1'b0, r_d}) : DIFF_W'(s2);

        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_q    = r_q;
        n_rem  = r_rem;
        n_d    = r_d;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_q    = i_dividend;
            n_rem  = '0;
            n_d    = i_divisor;
        end else if (r_busy) begin
            n_q   = {r_q[PROD_W-3:0], ge1, ge2};
            n_rem = rem2;
            n_step = r_step + STEP_W'(1);
            if (r_step == STEP_W'(STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_step <= n_step;
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_d    <= n_d;
    end

    // remainder at least half the divisor rounds the magnitude up
    assign o_done     = r_done;
    assign o_quot     = r_q;
    assign o_round_up = {r_rem, 1'b0} >= {1'b0, r_d};
endmodule

### sv/piecewise_linear_interpolator_core.sv
// top level of the piecewise linear interpolator: table control, search and arithmetic
//
//  channel   | direction | handshake                       | payload
//  ----------+-----------+---------------------------------+-----------------------
//  input     | in        | i_in_valid / o_in_stall         | i_in_data  (t_in_item)
//  output    | out       | o_out_valid / i_out_stall       | o_out_data (t_out_item)
//  config    | in        | psel, penable, pwrite, pready   | paddr, pwdata, prdata
//
//  one transaction at a time; clear, no-op and rejected loads go straight to the
//  result; a load into an empty table writes at once, otherwise the one-read-port
//  table scan shifts each larger entry up before the new one is written
//  a query that holds an end value skips the divider; otherwise a binary search
//  over the table ram (one probe per cycle, up to six) and the wait on the
//  33-step radix-4 divider dominate
//  synchronous active-low reset clears the point count and configuration;
//  table ram contents are left as they are
//  a finished result waits in the output register while the next transaction
//  is taken; a stalled output only holds the block once a second result is ready
module piecewise_linear_interpolator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pli_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pli_pkg::t_out_item  o_out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pli_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_LD_CMP  = 12'b0000_0000_0010,
        S_LD_LAST = 12'b0000_0000_0100,
        S_Q_HN    = 12'b0000_0000_1000,
        S_Q_L0    = 12'b0000_0001_0000,
        S_Q_OTH   = 12'b0000_0010_0000,
        S_Q_SRCH  = 12'b0000_0100_0000,
        S_DIFF    = 12'b0000_1000_0000,
        S_MUL     = 12'b0001_0000_0000,
        S_DSTART  = 12'b0010_0000_0000,
        S_DIV     = 12'b0100_0000_0000,
        S_FIN     = 12'b1000_0000_0000
    } t_state;

    // control registers
    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_flat, r_swap;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    // transaction and search registers
    logic signed [DATA_W-1:0] r_key, n_key;
    logic signed [DATA_W-1:0] r_val, n_val;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [IDX_W-1:0]   r_lo, n_lo;
    logic [IDX_W-1:0]   r_hi, n_hi;
    logic [IDX_W-1:0]   r_mid, n_mid;
    logic               r_high, n_high;
    t_entry             r_lo_ent, n_lo_ent;
    t_entry             r_hi_ent, n_hi_ent;
    t_entry             r_b, n_b;
    t_entry             r_o, n_o;

    // arithmetic registers
    logic               r_neg, n_neg;
    logic [DIFF_W-1:0]  r_mv, n_mv;
    logic [DIFF_W-1:0]  r_mq, n_mq;
    logic [DIFF_W-1:0]  r_mk, n_mk;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic signed [DATA_W-1:0] r_res_val, n_res_val;
    logic [2:0]         r_res_st, n_res_st;

    // table ram port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr, ram_raddr;
    t_entry             ram_wdata, rd;

    // divider port
    logic               div_start, div_done, div_round;
    logic [PROD_W-1:0]  div_quot;

    logic               in_acc, cfg_wr;
    t_entry             new_ent;
    logic [IDX_W-1:0]   top_idx;
    logic [IDX_W-1:0]   s_lo, s_hi;
    t_entry             s_lo_ent, s_hi_ent;
    logic [IDX_W:0]     s_sum;
    logic signed [DIFF_W-1:0] dv, dq, dk;
    logic [PROD_W:0]    qm;
    logic signed [SUM_W-1:0] sb, qe, sum;
    logic signed [SUM_W-1:0] lim_hi, lim_lo;

    pli_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rd)
    );

    pli_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_prod),
        .i_divisor  (r_mk),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_round_up (div_round)
    );

    // configuration port, registers decoded on word address only
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? {31'b0, r_swap} : {31'b0, r_flat};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flat <= 1'b0;
            r_swap <= 1'b0;
        end else if (cfg_wr) begin
            if (paddr[2]) begin
                r_swap <= pwdata[0];
            end else begin
                r_flat <= pwdata[0];
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign top_idx = IDX_W'(r_cnt - CNT_W'(1));
    assign new_ent = '{key: r_key, value: r_val};

    // saturation bounds in the wide sum format
    assign lim_hi = SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
    assign lim_lo = SUM_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}));

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_key       = r_key;
        n_val       = r_val;
        n_j         = r_j;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_high      = r_high;
        n_lo_ent    = r_lo_ent;
        n_hi_ent    = r_hi_ent;
        n_b         = r_b;
        n_o         = r_o;
        n_neg       = r_neg;
        n_mv        = r_mv;
        n_mq        = r_mq;
        n_mk        = r_mk;
        n_prod      = r_prod;
        n_res_val   = r_res_val;
        n_res_st    = r_res_st;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = new_ent;
        ram_raddr = top_idx;
        div_start = 1'b0;

        s_lo     = r_lo;
        s_hi     = r_hi;
        s_lo_ent = r_lo_ent;
        s_hi_ent = r_hi_ent;
        s_sum    = '0;

        dv  = DIFF_W'(r_o.value) - DIFF_W'(r_b.value);
        dq  = DIFF_W'(r_key) - DIFF_W'(r_b.key);
        dk  = DIFF_W'(r_o.key) - DIFF_W'(r_b.key);
        qm  = {1'b0, div_quot} + (PROD_W+1)'(div_round);
        sb  = SUM_W'(r_b.value);
        qe  = SUM_W'(signed'({1'b0, qm}));
        sum = r_neg ? (sb - qe) : (sb + qe);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_key     = r_swap ? i_in_data.point_y : i_in_data.point_x;
                    n_val     = r_swap ? i_in_data.point_x : i_in_data.point_y;
                    n_res_val = '0;
                    n_res_st  = ST_OK;
                    n_state   = S_FIN;
                    unique case (t_mode'(i_in_data.mode))
                        MODE_CLEAR: begin
                            n_cnt = '0;
                        end
                        MODE_LOAD: begin
                            if (r_cnt >= CNT_W'(MAX_POINTS)) begin
                                n_res_st = ST_FULL;
                            end else if (r_cnt == '0) begin
                                ram_we    = 1'b1;
                                ram_waddr = '0;
                                ram_wdata = '{key: n_key, value: n_val};
                                n_cnt     = CNT_W'(1);
                            end else begin
                                // scan down from the top entry, shifting larger keys up
                                n_j     = top_idx;
                                n_state = S_LD_CMP;
                            end
                        end
                        MODE_QUERY: begin
                            n_key = i_in_data.query_value;
                            if (r_cnt < CNT_W'(2)) begin
                                n_res_st = ST_FEW;
                            end else begin
                                n_state = S_Q_HN;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_LD_CMP: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(r_j + IDX_W'(1));
                if (rd.key > r_key) begin
                    ram_wdata = rd;
                    if (r_j == '0) begin
                        n_state = S_LD_LAST;
                    end else begin
                        n_j       = IDX_W'(r_j - IDX_W'(1));
                        ram_raddr = IDX_W'(r_j - IDX_W'(1));
                    end
                end else begin
                    ram_wdata = new_ent;
                    n_cnt     = CNT_W'(r_cnt + CNT_W'(1));
                    n_state   = S_FIN;
                end
            end
            S_LD_LAST: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = new_ent;
                n_cnt     = CNT_W'(r_cnt + CNT_W'(1));
                n_state   = S_FIN;
            end
            S_Q_HN: begin
                n_hi_ent = rd;
                n_hi     = top_idx;
                if (r_key >= rd.key) begin
                    // at or beyond the high end
                    if (r_flat) begin
                        n_res_val = rd.value;
                        n_state   = S_FIN;
                    end else begin
                        ram_raddr = IDX_W'(top_idx - IDX_W'(1));
                        n_high    = 1'b1;
                        n_state   = S_Q_OTH;
                    end
                end else begin
                    ram_raddr = '0;
                    n_state   = S_Q_L0;
                end
            end
            S_Q_L0: begin
                n_lo_ent = rd;
                n_lo     = '0;
                if (r_key <= rd.key) begin
                    // at or below the low end
                    if (r_flat) begin
                        n_res_val = rd.value;
                        n_state   = S_FIN;
                    end else begin
                        ram_raddr = IDX_W'(1);
                        n_high    = 1'b0;
                        n_state   = S_Q_OTH;
                    end
                end else if (r_hi == IDX_W'(1)) begin
                    n_b     = rd;
                    n_o     = r_hi_ent;
                    n_state = S_DIFF;
                end else begin
                    n_mid     = IDX_W'(r_hi >> 1);
                    ram_raddr = IDX_W'(r_hi >> 1);
                    n_state   = S_Q_SRCH;
                end
            end
            S_Q_OTH: begin
                if (r_high) begin
                    n_b = r_hi_ent;
                    n_o = rd;
                end else begin
                    n_b = rd;
                    n_o = r_lo_ent;
                end
                n_state = S_DIFF;
            end
            S_Q_SRCH: begin
                // keep the last entry at or below the query as the lower bracket
                if (rd.key <= r_key) begin
                    s_lo     = r_mid;
                    s_lo_ent = rd;
                end else begin
                    s_hi     = r_mid;
                    s_hi_ent = rd;
                end
                n_lo     = s_lo;
                n_hi     = s_hi;
                n_lo_ent = s_lo_ent;
                n_hi_ent = s_hi_ent;
                s_sum    = {1'b0, s_lo} + {1'b0, s_hi};
                if (IDX_W'(s_hi - s_lo) > IDX_W'(1)) begin
                    n_mid     = s_sum[IDX_W:1];
                    ram_raddr = s_sum[IDX_W:1];
                end else begin
                    n_b     = s_lo_ent;
                    n_o     = s_hi_ent;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_neg = dv[DIFF_W-1] ^ dq[DIFF_W-1] ^ dk[DIFF_W-1];
                n_mv  = dv[DIFF_W-1] ? DIFF_W'(-dv) : DIFF_W'(dv);
                n_mq  = dq[DIFF_W-1] ? DIFF_W'(-dq) : DIFF_W'(dq);
                n_mk  = dk[DIFF_W-1] ? DIFF_W'(-dk) : DIFF_W'(dk);
                if (dk == '0) begin
                    n_res_st = ST_EQKEY;
                    n_state  = S_FIN;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = r_mv * r_mq;
                n_state = S_DSTART;
            end
            S_DSTART: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    if (sum > lim_hi) begin
                        n_res_val = lim_hi[DATA_W-1:0];
                        n_res_st  = ST_SAT;
                    end else if (sum < lim_lo) begin
                        n_res_val = lim_lo[DATA_W-1:0];
                        n_res_st  = ST_SAT;
                    end else begin
                        n_res_val = sum[DATA_W-1:0];
                    end
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.result_value = r_res_val;
                    n_out.status      = r_res_st;
                    n_out.point_count = r_cnt;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_out     <= n_out;
        r_key     <= n_key;
        r_val     <= n_val;
        r_j       <= n_j;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_mid     <= n_mid;
        r_high    <= n_high;
        r_lo_ent  <= n_lo_ent;
        r_hi_ent  <= n_hi_ent;
        r_b       <= n_b;
        r_o       <= n_o;
        r_neg     <= n_neg;
        r_mv      <= n_mv;
        r_mq      <= n_mq;
        r_mk      <= n_mk;
        r_prod    <= n_prod;
        r_res_val <= n_res_val;
        r_res_st  <= n_res_st;
    end

    // table never holds more than its depth
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(MAX_POINTS))
        else $error("point count beyond table depth");

    // writes stay within the filled part plus the slot being added
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ({1'b0, ram_waddr} <= r_cnt))
        else $error("table write beyond fill level");

    // search brackets stay ordered
    a_bracket: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_Q_SRCH) |-> (r_lo < r_mid) && (r_mid < r_hi))
        else $error("binary search bracket collapsed");

    // a saturated result always sits on a range limit
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_SAT) |->
        (r_out.result_value == lim_hi[DATA_W-1:0]) ||
        (r_out.result_value == lim_lo[DATA_W-1:0]))
        else $error("saturated result not at a limit");
endmodule

### test/tb_top.sv
// self-checking testbench of the piecewise linear interpolator core
`timescale 1ns / 1ps

module tb_top;
    import pli_pkg::*;

    localparam int  CLK_HALF    = 5;
    localparam int  TAIL_CYCLES = 80;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  PHASE_ITEMS = 250;
    localparam int  ADDR_FLAT   = 0;
    localparam int  ADDR_SWAP   = 4;
    localparam longint SAT_HI   = 64'sd2147483647;
    localparam longint SAT_LO   = -64'sd2147483648;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    piecewise_linear_interpolator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // shadow of the breakpoint table and registers
    longint    bp_key [MAX_POINTS];
    longint    bp_val [MAX_POINTS];
    int        bp_count = 0;
    bit        flat_mode = 1'b0;
    bit        swap_mode = 1'b0;

    t_out_item pending_results [$];
    int        mismatches = 0;
    int        cycles = 0;
    bit        gap_allowed = 1'b1;

    // vb + round(dv * dq / dk), ties away from zero, magnitude capped at 2^60
    function automatic longint lerp_value(longint vb, longint dv, longint dq, longint dk);
        logic [127:0] mv, mq, mk, prod, quo, rem;
        bit           neg;
        neg  = (dv < 0) ^ (dq < 0) ^ (dk < 0);
        mv   = 128'(dv < 0 ? -dv : dv);
        mq   = 128'(dq < 0 ? -dq : dq);
        mk   = 128'(dk < 0 ? -dk : dk);
        prod = mv * mq;
        quo  = prod / mk;
        rem  = prod % mk;
        if (rem >= mk - rem) begin
            quo = quo + 1;
        end
        if (quo > (128'd1 << 60)) begin
            quo = 128'd1 << 60;
        end
        return neg ? vb - longint'(quo[63:0]) : vb + longint'(quo[63:0]);
    endfunction

    // advances the shadow table by one transaction and returns its result
    function automatic t_out_item interpolate_step(t_in_item it);
        t_out_item r;
        longint    k, v, q, res;
        int        pos, n, lo;
        bit        eq_err;
        r      = '0;
        res    = 0;
        eq_err = 1'b0;
        case (t_mode'(it.mode))
            MODE_CLEAR: begin
                bp_count = 0;
            end
            MODE_LOAD: begin
                if (bp_count >= MAX_POINTS) begin
                    r.status = ST_FULL;
                end else begin
                    k   = swap_mode ? longint'(it.point_y) : longint'(it.point_x);
                    v   = swap_mode ? longint'(it.point_x) : longint'(it.point_y);
                    pos = 0;
                    while (pos < bp_count && bp_key[pos] <= k) pos++;
                    for (int j = bp_count; j > pos; j--) begin
                        bp_key[j] = bp_key[j-1];
                        bp_val[j] = bp_val[j-1];
                    end
                    bp_key[pos] = k;
                    bp_val[pos] = v;
                    bp_count++;
                end
            end
            MODE_QUERY: begin
                if (bp_count < 2) begin
                    r.status = ST_FEW;
                end else begin
                    q = longint'(it.query_value);
                    n = bp_count - 1;
                    if (q >= bp_key[n]) begin
                        // high end wins when both ends apply
                        if (flat_mode) res = bp_val[n];
                        else if (bp_key[n] == bp_key[n-1]) eq_err = 1'b1;
                        else res = lerp_value(bp_val[n], bp_val[n] - bp_val[n-1],
                                              q - bp_key[n], bp_key[n] - bp_key[n-1]);
                    end else if (q <= bp_key[0]) begin
                        if (flat_mode) res = bp_val[0];
                        else if (bp_key[1] == bp_key[0]) eq_err = 1'b1;
                        else res = lerp_value(bp_val[1], bp_val[1] - bp_val[0],
                                              q - bp_key[1], bp_key[1] - bp_key[0]);
                    end else begin
                        lo = 0;
                        while (lo + 1 <= n && bp_key[lo+1] <= q) lo++;
                        if (bp_key[lo] == q) res = bp_val[lo];
                        else res = lerp_value(bp_val[lo], bp_val[lo+1] - bp_val[lo],
                                              q - bp_key[lo], bp_key[lo+1] - bp_key[lo]);
                    end
                    if (eq_err) begin
                        r.status = ST_EQKEY;
                        res      = 0;
                    end else if (res > SAT_HI) begin
                        res      = SAT_HI;
                        r.status = ST_SAT;
                    end else if (res < SAT_LO) begin
                        res      = SAT_LO;
                        r.status = ST_SAT;
                    end
                end
            end
            default: ;
        endcase
        r.result_value = res[DATA_W-1:0];
        r.point_count  = CNT_W'(bp_count);
        return r;
    endfunction

    // offers one transaction after a gap, keeping valid high across back-to-back items
    task automatic send_item(t_in_item it, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic send_checked(t_in_item it, bit typed, t_out_item typed_res);
        t_out_item r;
        send_item(it, pick_gap());
        r = interpolate_step(it);
        pending_results.push_back(typed ? typed_res : r);
    endtask

    function automatic int pick_gap();
        int p;
        if (!gap_allowed) return 0;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 90) return $urandom_range(1, 3);
        if (p < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    task automatic reg_write(int addr, bit val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(addr);
        pwdata  <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_FLAT) flat_mode = val;
        else swap_mode = val;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] pick_coord();
        int p;
        p = $urandom_range(0, 99);
        if (p < 40) return $signed($urandom_range(0, 2000)) - 1000;
        if (p < 70) return $signed(32'($urandom_range(0, 32'h00ff_ffff))) - 32'sh0080_0000;
        if (p < 80) return ($urandom_range(0, 1)) ? 32'sh7fff_ffff : 32'sh8000_0000;
        return $signed($urandom());
    endfunction

    function automatic logic signed [31:0] pick_query();
        int p;
        p = $urandom_range(0, 99);
        if (bp_count > 0 && p < 50) begin
            // near a stored key, often exactly on it
            return DATA_W'(bp_key[$urandom_range(0, bp_count - 1)]
                           + $signed($urandom_range(0, 8)) - 4);
        end
        return pick_coord();
    endfunction

    function automatic t_in_item make_item(t_mode m, logic signed [31:0] x,
                                           logic signed [31:0] y, logic signed [31:0] q);
        t_in_item it;
        it.mode        = m;
        it.point_x     = x;
        it.point_y     = y;
        it.query_value = q;
        return it;
    endfunction

    function automatic t_out_item make_res(logic signed [31:0] v, t_status s, int cnt);
        t_out_item r;
        r.result_value = v;
        r.status       = s;
        r.point_count  = CNT_W'(cnt);
        return r;
    endfunction

    // one well-formed sequence: usually a clear, a batch of loads, then queries
    task automatic random_sequence(ref int sent);
        int npts, nq, p;
        p = $urandom_range(0, 99);
        if ($urandom_range(0, 9) != 0) begin
            send_checked(make_item(MODE_CLEAR, pick_coord(), pick_coord(), pick_coord()),
                         1'b0, '0);
            sent++;
        end
        if (p < 8) npts = $urandom_range(0, 1);
        else if (p < 12) npts = $urandom_range(MAX_POINTS - 4, MAX_POINTS + 3);
        else npts = $urandom_range(2, 8);
        for (int i = 0; i < npts; i++) begin
            send_checked(make_item(MODE_LOAD, pick_coord(), pick_coord(), pick_coord()),
                         1'b0, '0);
            sent++;
        end
        nq = $urandom_range(1, 12);
        for (int i = 0; i < nq; i++) begin
            // occasional noise: no-op or a stray load between queries
            p = $urandom_range(0, 99);
            send_checked(make_item(p < 5 ? MODE_NOP : (p < 9 ? MODE_LOAD : MODE_QUERY),
                                   pick_coord(), pick_coord(), pick_query()), 1'b0, '0);
            sent++;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result value=%0d status=%0d count=%0d",
                             out_data.result_value, out_data.status, out_data.point_count);
            end else begin
                want = pending_results.pop_front();
                if (out_data.result_value !== want.result_value
                        || out_data.status !== want.status
                        || out_data.point_count !== want.point_count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp value=%0d status=%0d count=%0d, got value=%0d status=%0d count=%0d",
                                 want.result_value, want.status, want.point_count,
                                 out_data.result_value, out_data.status, out_data.point_count);
                end
            end
        end
    end

    // receiver stalls: random runs plus one long hold to back the block up
    int stall_left = 0;
    int hold_left  = 0;
    bit hold_done  = 1'b0;
    always @(posedge i_clk) begin
        int p;
        if (!hold_done && cycles == 4000) begin
            hold_left = 2500;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
        end else begin
            p = $urandom_range(0, 99);
            out_stall  <= (p < 35) && gap_allowed;
            stall_left = (p < 90) ? $urandom_range(0, 3) : $urandom_range(10, 120);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int sent;
        bit flat_set [8] = '{0, 1, 0, 1, 0, 1, 1, 0};
        bit swap_set [8] = '{0, 0, 1, 1, 1, 0, 1, 0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, ends, exact keys, equal end keys, saturation
        send_checked(make_item(MODE_QUERY, 0, 0, 0), 1'b1, make_res(0, ST_FEW, 0));
        send_checked(make_item(MODE_NOP, -1, -1, -1), 1'b1, make_res(0, ST_OK, 0));
        send_checked(make_item(MODE_CLEAR, 0, 0, 0), 1'b1, make_res(0, ST_OK, 0));
        send_checked(make_item(MODE_LOAD, 0, 0, 0), 1'b1, make_res(0, ST_OK, 1));
        send_checked(make_item(MODE_QUERY, 0, 0, 0), 1'b1, make_res(0, ST_FEW, 1));
        send_checked(make_item(MODE_LOAD, 32'sh000a_0000, 32'sh0014_0000, 0),
                     1'b1, make_res(0, ST_OK, 2));
        send_checked(make_item(MODE_QUERY, 0, 0, 32'sh0005_0000), 1'b0, '0);
        send_checked(make_item(MODE_QUERY, 0, 0, 32'sh000a_0000), 1'b0, '0);
        send_checked(make_item(MODE_QUERY, 0, 0, 32'sh7fff_ffff), 1'b1,
                     make_res(32'sh7fff_ffff, ST_SAT, 2));
        send_checked(make_item(MODE_QUERY, 0, 0, 32'sh8000_0000), 1'b1,
                     make_res(32'sh8000_0000, ST_SAT, 2));
        send_checked(make_item(MODE_QUERY, 0, 0, -3), 1'b0, '0);
        send_checked(make_item(MODE_LOAD, 32'sh000a_0000, 7, 0), 1'b0, '0);
        send_checked(make_item(MODE_LOAD, 32'sh0004_0000, 3, 0), 1'b0, '0);
        send_checked(make_item(MODE_QUERY, 0, 0, 32'sh0004_0000), 1'b0, '0);
        send_checked(make_item(MODE_QUERY, 0, 0, 32'sh000a_0000), 1'b0, '0);
        send_checked(make_item(MODE_QUERY, 0, 0, 32'sh0007_8000), 1'b0, '0);
        send_checked(make_item(MODE_CLEAR, 5, 5, 5), 1'b1, make_res(0, ST_OK, 0));
        send_checked(make_item(MODE_LOAD, 5, 1, 0), 1'b0, '0);
        send_checked(make_item(MODE_LOAD, 5, 2, 0), 1'b0, '0);
        send_checked(make_item(MODE_QUERY, 0, 0, 9), 1'b1, make_res(0, ST_EQKEY, 2));
        send_checked(make_item(MODE_QUERY, 0, 0, 1), 1'b1, make_res(0, ST_EQKEY, 2));
        send_checked(make_item(MODE_CLEAR, 0, 0, 0), 1'b0, '0);
        send_checked(make_item(MODE_LOAD, 32'sh8000_0000, 32'sh8000_0000, 0), 1'b0, '0);
        send_checked(make_item(MODE_LOAD, 32'sh7fff_ffff, 32'sh7fff_ffff, 0), 1'b0, '0);
        send_checked(make_item(MODE_QUERY, 0, 0, 32'sh1234_5678), 1'b0, '0);
        drain();

        // random phases over register settings, both extremes included
        for (int ph = 0; ph < 8; ph++) begin
            reg_write(ADDR_FLAT, flat_set[ph]);
            reg_write(ADDR_SWAP, swap_set[ph]);
            gap_allowed = (ph != 6);
            sent = 0;
            while (sent < PHASE_ITEMS) random_sequence(sent);
            drain();
        end

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
